/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the max-XOR trie block.
// Each macro clocks on clk_i and holds off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RMXT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define RMXT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

/* hdl/rmxt_pkg.sv */
// Package for the persistent max-XOR trie: parameter defaults, opcodes,
// status codes and controller state type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rmxt_pkg;

  // Default configuration of the block.
  localparam int KEY_BITS_DEF     = 30;
  localparam int MAX_VERSIONS_DEF = 1024;
  localparam int NODE_SLOTS_DEF   = 32768;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_VERSION = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INS,
    ST_QNODE,
    ST_QCMP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/rmxt_ram.sv */
// Generic synchronous RAM: one write port and two registered read ports.
// Used for the node store and the root table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic                     re_b_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/range_max_xor_trie.sv */
// Persistent binary trie with range max-XOR queries: top level.
// Uses rmxt_pkg, rmxt_ram and assert_macros.svh.
//
// Usage: an input transaction carries an opcode and its operands. An insert
// copies the key's path of base_version into fresh nodes, each with its
// count raised by one, and records the copied root as the next version. A
// query walks the roots of version_high and version_low in step from the top
// key bit down and returns the largest XOR of the key with any key inserted
// in that range. Every input transaction gives exactly one output transaction
// with new_version, max_xor and status.
// Both walks are paced by the node memory's registered read of each trie
// level, and a query level that follows the key-bit child needs a second
// read. Errors (unknown version, store full) are reported from the check
// state without a walk.
// One item is in flight at a time; a new one is accepted once the previous
// result has moved to the output register, even if that result is still
// waiting there. A stalled receiver holds the output register and, once a
// second result is ready, the walk waits until the first is taken.
// Reset empties the trie at once: version 0 is the empty trie, no memory
// clearing pass is needed and the block is ready straight out of reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module range_max_xor_trie #(
  parameter int KEY_BITS     = rmxt_pkg::KEY_BITS_DEF,
  parameter int MAX_VERSIONS = rmxt_pkg::MAX_VERSIONS_DEF,
  parameter int NODE_SLOTS   = rmxt_pkg::NODE_SLOTS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                opcode_i,
  input  wire logic [$clog2(MAX_VERSIONS+1)-1:0]   base_version_i,
  input  wire logic [KEY_BITS-1:0]                 key_value_i,
  input  wire logic [$clog2(MAX_VERSIONS+1)-1:0]   version_low_i,
  input  wire logic [$clog2(MAX_VERSIONS+1)-1:0]   version_high_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [$clog2(MAX_VERSIONS+1)-1:0]   new_version_o,
  output logic      [KEY_BITS-1:0]                 max_xor_o,
  output logic      [rmxt_pkg::STATUS_W-1:0]       status_o
);

  import rmxt_pkg::*;

  localparam int VER_W   = $clog2(MAX_VERSIONS + 1);
  localparam int VCNT_W  = $clog2(MAX_VERSIONS + 2);
  localparam int NODE_W  = $clog2(NODE_SLOTS);
  localparam int NFREE_W = $clog2(NODE_SLOTS + 1);
  localparam int NSUM_W  = $clog2(NODE_SLOTS + KEY_BITS + 2);
  localparam int CNT_W   = VER_W;
  localparam int NODE_DW = CNT_W + 2 * NODE_W;
  localparam int LVL_W   = $clog2(KEY_BITS + 1);

  // Controller and walk state.
  state_e               state_q, state_d;
  logic                 op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [VER_W-1:0]     va_q;
  logic [VER_W-1:0]     vb_q;
  logic [LVL_W-1:0]     lvl_q, lvl_d;
  logic [KEY_BITS-1:0]  best_q, best_d;
  logic [NODE_DW-1:0]   hi_node_q, hi_node_d;
  logic [NODE_DW-1:0]   lo_node_q, lo_node_d;
  logic [VCNT_W-1:0]    vcnt_q, vcnt_d;
  logic [NFREE_W-1:0]   nfree_q, nfree_d;
  logic [VER_W-1:0]     res_ver_q, res_ver_d;
  logic [KEY_BITS-1:0]  res_xor_q, res_xor_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [VER_W-1:0]     out_ver_q;
  logic [KEY_BITS-1:0]  out_xor_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic                 root_za_q, root_zb_q;
  logic                 node_za_q, node_zb_q;

  // Memory ports.
  logic                 root_re, root_we;
  logic [VER_W-1:0]     root_raddr_a, root_raddr_b, root_waddr;
  logic [NODE_W-1:0]    root_wdata, root_rdata_a, root_rdata_b;
  logic                 node_re, node_we;
  logic [NODE_W-1:0]    node_raddr_a, node_raddr_b, node_waddr;
  logic [NODE_DW-1:0]   node_wdata, node_rdata_a, node_rdata_b;

  // Decoded data.
  logic                 in_fire;
  logic                 out_load;
  logic [NODE_W-1:0]    root_a, root_b;
  logic [NODE_DW-1:0]   node_a, node_b;
  logic [CNT_W-1:0]     a_cnt, b_cnt;
  logic [NODE_W-1:0]    a_c0, a_c1, b_c0, b_c1;
  logic [NODE_W-1:0]    h_c0, h_c1, l_c0, l_c1;
  logic [KEY_BITS-1:0]  key_sh, key_sh_nx, bit_mask;
  logic                 kbit, kbit_nx;
  logic                 taken;
  logic                 err_ver, err_full;
  logic [NODE_W-1:0]    nidx, nnext;
  logic [CNT_W-1:0]     ins_cnt;
  logic [NODE_W-1:0]    ins_c0, ins_c1;

  // Root table: entry v holds the root node of version v.
  rmxt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_VERSIONS + 1)
  ) u_root_ram (
    .clk_i     (clk_i),
    .we_i      (root_we),
    .waddr_i   (root_waddr),
    .wdata_i   (root_wdata),
    .re_a_i    (root_re),
    .raddr_a_i (root_raddr_a),
    .rdata_a_o (root_rdata_a),
    .re_b_i    (root_re),
    .raddr_b_i (root_raddr_b),
    .rdata_b_o (root_rdata_b)
  );

  // Node store: {count, child1, child0} per node.
  rmxt_ram #(
    .WIDTH (NODE_DW),
    .DEPTH (NODE_SLOTS)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (node_we),
    .waddr_i   (node_waddr),
    .wdata_i   (node_wdata),
    .re_a_i    (node_re),
    .raddr_a_i (node_raddr_a),
    .rdata_a_o (node_rdata_a),
    .re_b_i    (node_re),
    .raddr_b_i (node_raddr_b),
    .rdata_b_o (node_rdata_b)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Entry 0 of both memories is never written; it reads as the empty value.
  assign root_a = root_za_q ? '0 : root_rdata_a;
  assign root_b = root_zb_q ? '0 : root_rdata_b;
  assign node_a = node_za_q ? '0 : node_rdata_a;
  assign node_b = node_zb_q ? '0 : node_rdata_b;

  // Node field split.
  assign a_cnt = node_a[NODE_DW-1 -: CNT_W];
  assign a_c1  = node_a[2*NODE_W-1 -: NODE_W];
  assign a_c0  = node_a[NODE_W-1:0];
  assign b_cnt = node_b[NODE_DW-1 -: CNT_W];
  assign b_c1  = node_b[2*NODE_W-1 -: NODE_W];
  assign b_c0  = node_b[NODE_W-1:0];
  assign h_c1  = hi_node_q[2*NODE_W-1 -: NODE_W];
  assign h_c0  = hi_node_q[NODE_W-1:0];
  assign l_c1  = lo_node_q[2*NODE_W-1 -: NODE_W];
  assign l_c0  = lo_node_q[NODE_W-1:0];

  // Key bit of the current level and of the level below it.
  assign key_sh    = key_q >> (lvl_q - LVL_W'(1));
  assign key_sh_nx = key_q >> (lvl_q - LVL_W'(2));
  assign kbit      = key_sh[0];
  assign kbit_nx   = key_sh_nx[0];
  assign bit_mask  = KEY_BITS'(1) << (lvl_q - LVL_W'(1));
  assign taken     = a_cnt > b_cnt;

  // Version and capacity checks on the captured transaction.
  always_comb begin
    err_ver = VCNT_W'(va_q) >= vcnt_q;
    if (op_q == OP_QUERY) begin
      err_ver = err_ver || (VCNT_W'(vb_q) >= vcnt_q);
    end
    err_full = (vcnt_q > VCNT_W'(MAX_VERSIONS)) ||
               ((NSUM_W'(nfree_q) + NSUM_W'(KEY_BITS + 1)) > NSUM_W'(NODE_SLOTS));
  end

  // Path copy: the new node takes the old counts plus one and, above the
  // leaf, points its key-bit child at the node allocated next.
  assign nidx    = nfree_q[NODE_W-1:0];
  assign nnext   = nidx + NODE_W'(1);
  assign ins_cnt = a_cnt + CNT_W'(1);
  assign ins_c0  = (lvl_q != '0 && !kbit) ? nnext : a_c0;
  assign ins_c1  = (lvl_q != '0 && kbit)  ? nnext : a_c1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (err_ver || (op_q == OP_INSERT && err_full)) begin
          state_d = ST_DONE;
        end else if (op_q == OP_INSERT) begin
          state_d = ST_INS;
        end else begin
          state_d = ST_QNODE;
        end
      end
      ST_INS: begin
        if (lvl_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_QNODE: begin
        state_d = ST_QCMP;
      end
      ST_QCMP: begin
        if (lvl_q == LVL_W'(1)) begin
          state_d = ST_DONE;
        end else if (!taken) begin
          state_d = ST_QNODE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory control and datapath updates.
  always_comb begin
    root_re      = 1'b0;
    root_raddr_a = (opcode_i == OP_INSERT) ? base_version_i : version_high_i;
    root_raddr_b = version_low_i;
    root_we      = 1'b0;
    root_waddr   = vcnt_q[VER_W-1:0];
    root_wdata   = nidx;
    node_re      = 1'b0;
    node_raddr_a = '0;
    node_raddr_b = '0;
    node_we      = 1'b0;
    node_waddr   = nidx;
    node_wdata   = {ins_cnt, ins_c1, ins_c0};
    lvl_d        = lvl_q;
    best_d       = best_q;
    hi_node_d    = hi_node_q;
    lo_node_d    = lo_node_q;
    vcnt_d       = vcnt_q;
    nfree_d      = nfree_q;
    res_ver_d    = res_ver_q;
    res_xor_d    = res_xor_q;
    res_status_d = res_status_q;
    case (state_q)
      ST_IDLE: begin
        root_re = in_fire;
      end
      ST_CHECK: begin
        res_ver_d = '0;
        res_xor_d = '0;
        lvl_d     = LVL_W'(KEY_BITS);
        best_d    = '0;
        if (err_ver) begin
          res_status_d = STATUS_NO_VERSION;
        end else if (op_q == OP_INSERT && err_full) begin
          res_status_d = STATUS_FULL;
        end else if (op_q == OP_INSERT) begin
          root_we      = 1'b1;
          node_re      = 1'b1;
          node_raddr_a = root_a;
        end else begin
          node_re      = 1'b1;
          node_raddr_a = root_a;
          node_raddr_b = root_b;
        end
      end
      ST_INS: begin
        node_we = 1'b1;
        nfree_d = nfree_q + NFREE_W'(1);
        if (lvl_q != '0) begin
          node_re      = 1'b1;
          node_raddr_a = kbit ? a_c1 : a_c0;
          lvl_d        = lvl_q - LVL_W'(1);
        end else begin
          res_ver_d    = vcnt_q[VER_W-1:0];
          res_xor_d    = '0;
          res_status_d = STATUS_OK;
          vcnt_d       = vcnt_q + VCNT_W'(1);
        end
      end
      ST_QNODE: begin
        // Current nodes arrive; fetch their children opposite to the key bit.
        hi_node_d    = node_a;
        lo_node_d    = node_b;
        node_re      = 1'b1;
        node_raddr_a = kbit ? a_c0 : a_c1;
        node_raddr_b = kbit ? b_c0 : b_c1;
      end
      ST_QCMP: begin
        best_d = taken ? (best_q | bit_mask) : best_q;
        if (lvl_q == LVL_W'(1)) begin
          res_ver_d    = '0;
          res_xor_d    = best_d;
          res_status_d = STATUS_OK;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          node_re = 1'b1;
          if (taken) begin
            // The opposite children are the next nodes: chain straight on.
            hi_node_d    = node_a;
            lo_node_d    = node_b;
            node_raddr_a = kbit_nx ? a_c0 : a_c1;
            node_raddr_b = kbit_nx ? b_c0 : b_c1;
          end else begin
            node_raddr_a = kbit ? h_c1 : h_c0;
            node_raddr_b = kbit ? l_c1 : l_c0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= VCNT_W'(1);
      nfree_q     <= NFREE_W'(1);
      out_valid_q <= 1'b0;
      root_za_q   <= 1'b1;
      root_zb_q   <= 1'b1;
      node_za_q   <= 1'b1;
      node_zb_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      vcnt_q      <= vcnt_d;
      nfree_q     <= nfree_d;
      out_valid_q <= out_valid_d;
      if (root_re) begin
        root_za_q <= (root_raddr_a == '0);
        root_zb_q <= (root_raddr_b == '0);
      end
      if (node_re) begin
        node_za_q <= (node_raddr_a == '0);
        node_zb_q <= (node_raddr_b == '0);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= opcode_i;
      key_q <= key_value_i;
      va_q  <= (opcode_i == OP_INSERT) ? base_version_i : version_high_i;
      vb_q  <= version_low_i;
    end
    lvl_q        <= lvl_d;
    best_q       <= best_d;
    hi_node_q    <= hi_node_d;
    lo_node_q    <= lo_node_d;
    res_ver_q    <= res_ver_d;
    res_xor_q    <= res_xor_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_ver_q    <= res_ver_q;
      out_xor_q    <= res_xor_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_version_o = out_ver_q;
  assign max_xor_o     = out_xor_q;
  assign status_o      = out_status_q;

  // Checks on the allocator and the result hand-off.
  `RMXT_ASSERT(a_nfree_bound, nfree_q <= NFREE_W'(NODE_SLOTS), "node allocator overran the store")
  `RMXT_ASSERT(a_node0_kept, node_we |-> node_waddr != '0, "write to the shared empty node")
  `RMXT_ASSERT_NEXT(a_vcnt_step, (state_q == ST_INS && lvl_q == '0), vcnt_q == $past(vcnt_q) + VCNT_W'(1), "version count not advanced after insert")
  `RMXT_ASSERT_NEXT(a_done_hold, (state_q == ST_DONE && out_valid_q && !out_ready_i), state_q == ST_DONE, "result dropped while output stalled")

endmodule

`default_nettype wire

/* dv/range_max_xor_trie_test.sv */
// Self-checking testbench for range_max_xor_trie: inserts and range max-XOR queries
// are checked against a shadow trie kept in the bench. Depends on rmxt_pkg and the
// RTL of range_max_xor_trie.
`timescale 1ns / 1ps

module range_max_xor_trie_test;

  import rmxt_pkg::*;

  localparam int KEY_BITS     = KEY_BITS_DEF;
  localparam int MAX_VERSIONS = MAX_VERSIONS_DEF;
  localparam int NODE_SLOTS   = NODE_SLOTS_DEF;
  localparam int VW           = $clog2(MAX_VERSIONS + 1);
  localparam int NIDX_W       = $clog2(NODE_SLOTS);
  localparam int CNT_W        = 11;
  localparam int unsigned KEY_MAX = (1 << KEY_BITS) - 1;
  localparam int RANDOM_CMDS  = 120;

  // One command as the bench queues it, with its pacing attributes.
  typedef struct packed {
    logic            hold;
    logic [1:0]      phase;
    logic            op;
    logic [VW-1:0]   base;
    logic [KEY_BITS-1:0] key;
    logic [VW-1:0]   lo;
    logic [VW-1:0]   hi;
  } trie_cmd_t;

  typedef struct packed {
    logic [VW-1:0]       new_version;
    logic [KEY_BITS-1:0] max_xor;
    logic [STATUS_W-1:0] status;
  } trie_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                opcode       = OP_INSERT;
  logic [VW-1:0]       base_version = '0;
  logic [KEY_BITS-1:0] key_value    = '0;
  logic [VW-1:0]       version_low  = '0;
  logic [VW-1:0]       version_high = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [VW-1:0]       new_version;
  logic [KEY_BITS-1:0] max_xor;
  logic [STATUS_W-1:0] status;

  range_max_xor_trie i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .base_version_i (base_version),
    .key_value_i    (key_value),
    .version_low_i  (version_low),
    .version_high_i (version_high),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .new_version_o  (new_version),
    .max_xor_o      (max_xor),
    .status_o       (status)
  );

  always #1 clk_i = ~clk_i;

  // Shadow trie: node counts, children, version roots and allocation pointers.
  logic [CNT_W-1:0]  trie_cnt [NODE_SLOTS];
  logic [NIDX_W-1:0] trie_kid [NODE_SLOTS][2];
  logic [NIDX_W-1:0] root_of  [MAX_VERSIONS + 1];
  int unsigned       ver_total;
  int unsigned       free_node;

  trie_cmd_t    cmd_queue[$];
  trie_result_t pending_results[$];
  trie_cmd_t    on_wire;
  int unsigned  sent_cnt = 0;
  int unsigned  recv_cnt = 0;
  int unsigned  mismatches = 0;
  logic [1:0]   cur_phase = 2'd0;
  int unsigned  gen_versions = 1;

  // Copy a node into the next free slot with its count raised by one.
  function automatic int unsigned clone_node(input int unsigned src);
    int unsigned n;
    n = free_node;
    trie_cnt[n]    = trie_cnt[src] + CNT_W'(1);
    trie_kid[n][0] = trie_kid[src][0];
    trie_kid[n][1] = trie_kid[src][1];
    free_node      = n + 1;
    return n;
  endfunction

  // Apply one command to the shadow trie and return the result it should give.
  function automatic trie_result_t trie_apply(input trie_cmd_t c);
    trie_result_t r;
    int unsigned  prev, parent, root, node, hi_n, lo_n, ch, cl;
    logic         kb;
    r = '0;
    if (c.op == OP_INSERT) begin
      if (c.base >= ver_total) begin
        r.status = STATUS_NO_VERSION;
      end else if (ver_total > MAX_VERSIONS || free_node + KEY_BITS + 1 > NODE_SLOTS) begin
        r.status = STATUS_FULL;
      end else begin
        prev   = 32'(root_of[c.base]);
        root   = clone_node(prev);
        parent = root;
        for (int bit_i = KEY_BITS - 1; bit_i >= 0; bit_i--) begin
          kb   = c.key[bit_i];
          prev = 32'(trie_kid[prev][kb]);
          node = clone_node(prev);
          trie_kid[parent][kb] = NIDX_W'(node);
          parent = node;
        end
        root_of[ver_total] = NIDX_W'(root);
        r.new_version = VW'(ver_total);
        ver_total++;
      end
    end else begin
      if (c.lo >= ver_total || c.hi >= ver_total) begin
        r.status = STATUS_NO_VERSION;
      end else begin
        hi_n = 32'(root_of[c.hi]);
        lo_n = 32'(root_of[c.lo]);
        // Take the opposite child whenever the range holds a key under it.
        for (int bit_i = KEY_BITS - 1; bit_i >= 0; bit_i--) begin
          kb = c.key[bit_i];
          ch = 32'(trie_kid[hi_n][!kb]);
          cl = 32'(trie_kid[lo_n][!kb]);
          if (trie_cnt[ch] > trie_cnt[cl]) begin
            r.max_xor[bit_i] = 1'b1;
            hi_n = ch;
            lo_n = cl;
          end else begin
            hi_n = 32'(trie_kid[hi_n][kb]);
            lo_n = 32'(trie_kid[lo_n][kb]);
          end
        end
      end
    end
    return r;
  endfunction

  // Queue a command and track how many versions the block will have made.
  function automatic void add_cmd(input logic op, input int unsigned base,
                                  input int unsigned key, input int unsigned lo,
                                  input int unsigned hi, input logic hold = 1'b0);
    trie_cmd_t c;
    c.hold  = hold;
    c.phase = 2'd0;
    c.op    = op;
    c.base  = VW'(base);
    c.key   = KEY_BITS'(key);
    c.lo    = VW'(lo);
    c.hi    = VW'(hi);
    cmd_queue = {cmd_queue, c};
    if (op == OP_INSERT && base < gen_versions && gen_versions <= MAX_VERSIONS) begin
      gen_versions++;
    end
  endfunction

  function automatic int unsigned any_known_version();
    return $urandom_range(gen_versions - 1);
  endfunction

  // Random key, biased now and then toward small or nearly full values or a one-bit change of the recent key.
  function automatic int unsigned pick_key(input int unsigned recent);
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return $urandom_range(15);
    if (roll == 1) return KEY_MAX - $urandom_range(15);
    if (roll <= 3) return recent ^ (1 << $urandom_range(KEY_BITS - 1));
    return $urandom_range(KEY_MAX);
  endfunction

  function automatic int unsigned tx_idle_pct(input logic [1:0] ph);
    return (ph == 2'd0) ? 17 : (ph == 2'd1) ? 71 : 0;
  endfunction

  function automatic int unsigned rx_idle_pct(input logic [1:0] ph);
    return (ph == 2'd0) ? 71 : (ph == 2'd1) ? 17 : 0;
  endfunction

  // Driver: predicts each accepted transaction and presents the next command.
  always @(posedge clk_i) begin : drive_proc
    logic        took;
    int unsigned owed;
    trie_cmd_t   nxt;
    if (rst_ni) begin
      took = in_valid && in_ready;
      if (took) begin
        pending_results = {pending_results, trie_apply(on_wire)};
        sent_cnt <= sent_cnt + 1;
      end
      owed = sent_cnt + took - recv_cnt;
      if (!in_valid || took) begin
        if (cmd_queue.size() != 0 && !(cmd_queue[0].hold && owed != 0) &&
            $urandom_range(99) >= tx_idle_pct(cmd_queue[0].phase)) begin
          nxt          = cmd_queue.pop_front();
          on_wire      = nxt;
          in_valid     <= 1'b1;
          opcode       <= nxt.op;
          base_version <= nxt.base;
          key_value    <= nxt.key;
          version_low  <= nxt.lo;
          version_high <= nxt.hi;
          cur_phase    <= nxt.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i) begin : check_proc
    trie_result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("Result transaction with no prediction waiting.");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (new_version !== want.new_version) begin
            $error("new_version: expected %0d, got %0d", want.new_version, new_version);
            mismatches++;
          end
          if (max_xor !== want.max_xor) begin
            $error("max_xor: expected %0h, got %0h", want.max_xor, max_xor);
            mismatches++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
        end
        recv_cnt <= recv_cnt + 1;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct(cur_phase));
    end
  end

  // Stimulus, reset and the final verdict.
  initial begin : main_proc
    int unsigned last_key;
    int unsigned roll, va, vb;
    // Shadow trie after reset: only the empty node and version 0 exist.
    trie_cnt[0]    = '0;
    trie_kid[0][0] = '0;
    trie_kid[0][1] = '0;
    root_of[0]     = '0;
    ver_total      = 1;
    free_node      = 1;
    last_key       = 0;

    // Directed opening: empty trie, unknown versions, extreme keys, reversed
    // and empty ranges, and branching from older versions.
    add_cmd(OP_QUERY,  0, 0, 0, 0);
    add_cmd(OP_INSERT, 1, 5, 0, 0);
    add_cmd(OP_QUERY,  0, 0, 1, 0);
    add_cmd(OP_QUERY,  0, 0, 0, MAX_VERSIONS);
    add_cmd(OP_INSERT, 0, 0, MAX_VERSIONS, MAX_VERSIONS);
    add_cmd(OP_INSERT, 1, KEY_MAX, 0, 0);
    add_cmd(OP_INSERT, 0, 30'h2AAA_AAAA, 0, 0);
    add_cmd(OP_QUERY,  0, 0, 0, 2);
    add_cmd(OP_QUERY,  0, KEY_MAX, 0, 2);
    add_cmd(OP_QUERY,  0, 0, 1, 2);
    add_cmd(OP_QUERY,  0, 0, 2, 1);
    add_cmd(OP_QUERY,  0, 30'h1555_5555, 0, 3);
    add_cmd(OP_QUERY,  0, 5, 2, 2);
    add_cmd(OP_INSERT, 2, 30'h2000_0000, 0, 0);
    add_cmd(OP_INSERT, MAX_VERSIONS, 7, 0, 0);
    add_cmd(OP_QUERY,  MAX_VERSIONS, KEY_MAX, 1, 4);
    add_cmd(OP_INSERT, 3, 1, 0, 0);
    add_cmd(OP_QUERY,  0, 30'h3FFF_FFFE, 3, 5);
    add_cmd(OP_QUERY,  0, 0, 5, 0);

    // Random part: mostly valid inserts and ranges, some noise.
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        add_cmd(1'($urandom_range(1)), $urandom_range(MAX_VERSIONS), $urandom_range(KEY_MAX),
                $urandom_range(MAX_VERSIONS), $urandom_range(MAX_VERSIONS), i == 0);
      end else if (roll < 65) begin
        last_key = pick_key(last_key);
        va = ($urandom_range(2) == 0) ? gen_versions - 1 : any_known_version();
        add_cmd(OP_INSERT, va, last_key, $urandom_range(MAX_VERSIONS),
                $urandom_range(MAX_VERSIONS), i == 0);
      end else begin
        va = any_known_version();
        vb = any_known_version();
        // Mostly proper ranges, with a few reversed ones.
        if ((va > vb) != ($urandom_range(9) == 0)) begin
          roll = va;
          va   = vb;
          vb   = roll;
        end
        add_cmd(OP_QUERY, $urandom_range(MAX_VERSIONS), pick_key(last_key ^ KEY_MAX),
                va, vb, i == 0);
      end
    end

    // Fill the version table, then run into the full condition and query the
    // highest version.
    while (gen_versions <= MAX_VERSIONS) begin
      last_key = pick_key(last_key);
      add_cmd(OP_INSERT, any_known_version(), last_key, 0, 0,
              gen_versions == MAX_VERSIONS);
    end
    add_cmd(OP_INSERT, MAX_VERSIONS, KEY_MAX, 0, 0);
    add_cmd(OP_INSERT, 0, 0, 0, 0);
    add_cmd(OP_INSERT, any_known_version(), $urandom_range(KEY_MAX), 0, 0);
    add_cmd(OP_QUERY, 0, 0, 0, MAX_VERSIONS);
    add_cmd(OP_QUERY, 0, KEY_MAX, 0, MAX_VERSIONS);
    add_cmd(OP_QUERY, 0, $urandom_range(KEY_MAX), MAX_VERSIONS, 0);
    for (int i = 0; i < 6; i++) begin
      va = any_known_version();
      add_cmd(OP_QUERY, 0, $urandom_range(KEY_MAX), va, va + $urandom_range(MAX_VERSIONS - va));
    end

    // Split the run into the three idling phases.
    foreach (cmd_queue[i]) begin
      cmd_queue[i].phase = 2'((i * 3) / cmd_queue.size());
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid || recv_cnt != sent_cnt) begin
      @(posedge clk_i);
    end
    repeat (2 * KEY_BITS + 8) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog well beyond the slowest expected run.
  initial begin : watchdog_proc
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/rmxt_pkg.sv
hdl/rmxt_ram.sv
hdl/range_max_xor_trie.sv
dv/range_max_xor_trie_test.sv
